// ===== hdl/sorted_key_override_table_core_defines.svh =====
// assertion macros for the sorted key override table
`ifndef SORTED_KEY_OVERRIDE_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_OVERRIDE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH
// checked property, masked while reset is high
`define SKOT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("skot assertion failed");
// checked property, live during reset as well
`define SKOT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("skot assertion failed");
`else
`define SKOT_ASSERT(lbl, clk, rst, prop)
`define SKOT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/skot_pkg.sv =====
// shared types and codes for the sorted key override table
`timescale 1ns / 1ps
`default_nettype none

package skot_pkg;

   localparam int KEY_PORT_BITS = 32;
   localparam int VAL_BITS      = 32;

   // request action codes; the unused code behaves as a lookup
   localparam logic [1:0] ACT_LOOKUP     = 2'd0;
   localparam logic [1:0] ACT_REGISTER   = 2'd1;
   localparam logic [1:0] ACT_UNREGISTER = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_SCAN,
      ST_UPD
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                     cmp;
      logic                     scan;
      logic                     insert;
      logic                     setval;
      logic [KEY_PORT_BITS-1:0] key;
      logic [VAL_BITS-1:0]      wval;
   } ctrl_type;

   // handed from one cell to the next one up
   typedef struct packed {
      logic                     valid;
      logic                     gt;
      logic                     hit;
      logic [KEY_PORT_BITS-1:0] key;
      logic [VAL_BITS-1:0]      value;
      logic [VAL_BITS-1:0]      hval;
   } link_type;

endpackage

`default_nettype wire

// ===== hdl/skot_cell.sv =====
// one table slot: entry storage, compare, hit ripple and shift-up insert
`timescale 1ns / 1ps
`default_nettype none

module skot_cell #(
   parameter int KEY_W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  skot_pkg::ctrl_type  ctrl,
   input  skot_pkg::link_type  link_in,
   output skot_pkg::link_type  link_out
);

   logic                          valid_ff, valid_in;
   logic                          eq_ff, eq_in;
   logic                          gt_ff, gt_in;
   logic                          hit_ff, hit_in;
   logic [KEY_W-1:0]              key_ff, key_in;
   logic [skot_pkg::VAL_BITS-1:0] val_ff, val_in;
   logic [skot_pkg::VAL_BITS-1:0] hval_ff, hval_in;
   logic                          shift_up;
   logic                          slot_here;

   // lower neighbour moves up when it is larger than the new key
   assign shift_up  = link_in.valid && link_in.gt;
   // first slot that is empty or larger, with a smaller-or-equal neighbour below
   assign slot_here = link_in.valid && !link_in.gt && (!valid_ff || gt_ff);

   always_comb begin
      valid_in = valid_ff;
      eq_in    = eq_ff;
      gt_in    = gt_ff;
      hit_in   = hit_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      hval_in  = hval_ff;
      if (ctrl.cmp) begin
         eq_in   = valid_ff && (key_ff == ctrl.key[KEY_W-1:0]);
         gt_in   = valid_ff && (key_ff > ctrl.key[KEY_W-1:0]);
         hit_in  = 1'b0;
         hval_in = '0;
      end
      if (ctrl.scan) begin
         hit_in  = link_in.hit | eq_ff;
         hval_in = eq_ff ? val_ff : link_in.hval;
      end
      if (ctrl.insert) begin
         if (shift_up) begin
            valid_in = 1'b1;
            key_in   = link_in.key[KEY_W-1:0];
            val_in   = link_in.value;
         end else if (slot_here) begin
            valid_in = 1'b1;
            key_in   = ctrl.key[KEY_W-1:0];
            val_in   = ctrl.wval;
         end
      end
      if (ctrl.setval && eq_ff) begin
         val_in = ctrl.wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         eq_ff    <= 1'b0;
         gt_ff    <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         eq_ff    <= eq_in;
         gt_ff    <= gt_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      val_ff  <= val_in;
      hval_ff <= hval_in;
   end

   always_comb begin
      link_out            = '0;
      link_out.valid      = valid_ff;
      link_out.gt         = gt_ff;
      link_out.hit        = hit_ff;
      link_out.key[KEY_W-1:0] = key_ff;
      link_out.value      = val_ff;
      link_out.hval       = hval_ff;
   end

endmodule

`default_nettype wire

// ===== hdl/sorted_key_override_table_core.sv =====
// top level: sorted key/value table built as a row of slot cells
// a request runs the compare, scan and update steps, then its result is registered
// the cells' hit ripple sets the scan; a new request is taken only after the last is done
// busy stays high from acceptance until the result strobe; the receiver cannot stall
// reset (synchronous, active high) empties the table and drops any request in flight
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_key_override_table_core_defines.svh"

module sorted_key_override_table_core #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_key,
   input  logic [31:0] req_new_value,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [31:0] rsp_stored_value,
   output logic [31:0] rsp_resolved_key,
   output logic        rsp_table_full
);

   // stored key width: the port carries at most 32 key bits
   localparam int KEY_W = (KEY_BITS < skot_pkg::KEY_PORT_BITS) ?
                          KEY_BITS : skot_pkg::KEY_PORT_BITS;
   localparam int CNT_W = $clog2(TABLE_DEPTH);

   skot_pkg::state_type state_ff, state_in;

   // held request
   logic [1:0]  act_ff, act_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] nval_ff, nval_in;

   // scan step counter
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic        found_ff, found_in;
   logic [31:0] stored_ff, stored_in;
   logic [31:0] resolved_ff, resolved_in;
   logic        full_ff, full_in;

   skot_pkg::ctrl_type ctrl;
   skot_pkg::link_type link_w [0:TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_vec;

   // top-of-chain view
   logic        last_hit;
   logic        last_valid;
   logic        is_reg;
   logic        is_unreg;
   logic        drop_full;

   assign busy = (state_ff != skot_pkg::ST_IDLE);

   // ---------------------------------------------------------------
   // row of cells; below cell 0 sits a virtual entry that is valid,
   // never larger than the key and never a hit
   // ---------------------------------------------------------------
   always_comb begin
      link_w[0]       = '0;
      link_w[0].valid = 1'b1;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      skot_cell #(
         .KEY_W (KEY_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .link_in  (link_w[i]),
         .link_out (link_w[i+1])
      );
      assign valid_vec[i] = link_w[i+1].valid;
   end

   assign last_hit   = link_w[TABLE_DEPTH].hit;
   assign last_valid = link_w[TABLE_DEPTH].valid;
   assign is_reg     = (act_ff == skot_pkg::ACT_REGISTER);
   assign is_unreg   = (act_ff == skot_pkg::ACT_UNREGISTER);
   // new key with every slot taken
   assign drop_full  = is_reg && !last_hit && last_valid;

   // ---------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skot_pkg::ST_IDLE: begin
            if (start) state_in = skot_pkg::ST_CMP;
         end
         skot_pkg::ST_CMP: begin
            state_in = skot_pkg::ST_SCAN;
         end
         skot_pkg::ST_SCAN: begin
            if (cnt_ff == CNT_W'(TABLE_DEPTH - 1)) state_in = skot_pkg::ST_UPD;
         end
         skot_pkg::ST_UPD: begin
            state_in = skot_pkg::ST_IDLE;
         end
         default: begin
            state_in = skot_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer: cell controls
   // ---------------------------------------------------------------
   always_comb begin
      ctrl      = '0;
      ctrl.key  = '0;
      ctrl.key[KEY_W-1:0] = key_ff[KEY_W-1:0];
      ctrl.wval = is_reg ? nval_ff : '0;
      case (state_ff)
         skot_pkg::ST_CMP: begin
            ctrl.cmp = 1'b1;
         end
         skot_pkg::ST_SCAN: begin
            ctrl.scan = 1'b1;
         end
         skot_pkg::ST_UPD: begin
            ctrl.insert = is_reg && !last_hit && !last_valid;
            ctrl.setval = last_hit && (is_reg || is_unreg);
         end
         default: begin
            ctrl.cmp = 1'b0;
         end
      endcase
   end

   // request capture and scan counter
   always_comb begin
      act_in  = act_ff;
      key_in  = key_ff;
      nval_in = nval_ff;
      cnt_in  = cnt_ff;
      if ((state_ff == skot_pkg::ST_IDLE) && start) begin
         act_in  = req_action;
         key_in  = req_key;
         nval_in = req_new_value;
      end
      if (state_ff == skot_pkg::ST_CMP) cnt_in = '0;
      if (state_ff == skot_pkg::ST_SCAN) cnt_in = cnt_ff + CNT_W'(1);
   end

   // result forming, taken from the top of the chain in the update step
   always_comb begin
      rsp_valid_in = (state_ff == skot_pkg::ST_UPD);
      found_in     = found_ff;
      stored_in    = stored_ff;
      resolved_in  = resolved_ff;
      full_in      = full_ff;
      if (state_ff == skot_pkg::ST_UPD) begin
         found_in = last_hit;
         full_in  = drop_full;
         if (is_reg) begin
            stored_in = drop_full ? '0 : nval_ff;
         end else if (is_unreg) begin
            stored_in = '0;
         end else begin
            stored_in = last_hit ? link_w[TABLE_DEPTH].hval : '0;
         end
         resolved_in = (stored_in != '0) ? stored_in : key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skot_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      nval_ff     <= nval_in;
      found_ff    <= found_in;
      stored_ff   <= stored_in;
      resolved_ff <= resolved_in;
      full_ff     <= full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_stored_value = stored_ff;
   assign rsp_resolved_key = resolved_ff;
   assign rsp_table_full   = full_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // a result strobe only ever follows the update step
   `SKOT_ASSERT(a_rsp_after_upd, clock, reset, rsp_valid |-> $past(state_ff == skot_pkg::ST_UPD))
   // a dropped register never reports a hit
   `SKOT_ASSERT(a_full_not_found, clock, reset, rsp_valid |-> !(rsp_found && rsp_table_full))
   // occupied slots always form one run from the bottom of the row
   `SKOT_ASSERT(a_valid_run, clock, reset, (valid_vec & (valid_vec + TABLE_DEPTH'(1))) == '0)
   // accepted request starts the compare step
   `SKOT_ASSERT(a_accept_cmp, clock, reset, (start && !busy) |=> (state_ff == skot_pkg::ST_CMP))
   // table reported full only when the top slot is taken
   `SKOT_ASSERT(a_full_top, clock, reset, (rsp_valid && rsp_table_full) |-> valid_vec[TABLE_DEPTH-1])

endmodule

`default_nettype wire
